FILE: sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int TimeW  = 12;
    localparam int NumCfg = 8;
    localparam int CfgIdxW = $clog2(NumCfg);
    localparam int BitCntW = 3;

    // Command codes carried by op
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_NODEV = 2'd2;
    localparam logic [1:0] ST_BUSY  = 2'd3;

    // Timing register indexes
    localparam logic [CfgIdxW-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_CHK  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRES_WAIT  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RESET_TAIL = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SLOT_EDGE  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_WRITE_SLOT = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_READ_SAMP  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_READ_TAIL  = 3'd7;

    localparam logic [BitCntW-1:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic       pull_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
    } t_result;

    function automatic logic [TimeW-1:0] cfg_reset_val(input logic [CfgIdxW-1:0] idx);
        logic [TimeW-1:0] v;
        case (idx)
            CFG_RESET_LOW:  v = 12'd500;
            CFG_SHORT_CHK:  v = 12'd5;
            CFG_PRES_WAIT:  v = 12'd80;
            CFG_RESET_TAIL: v = 12'd420;
            CFG_SLOT_EDGE:  v = 12'd2;
            CFG_WRITE_SLOT: v = 12'd60;
            CFG_READ_SAMP:  v = 12'd18;
            default:        v = 12'd44;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Timed 1-Wire bus master driven by microsecond ticks and commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request per item:
//   a tick (i_op = tick) with the sampled bus level on i_line_level, or a
//   command (bus reset, write byte from i_tx_byte, read byte). Every request
//   produces exactly one result on the output channel (o_out_valid /
//   i_out_stall): the drive for the coming microsecond on o_pull_low, busy,
//   done, status and the received byte on the done result of a read.
//   Results are registered in the output register. Throughput: one request
//   per cycle while o_in_stall is low; the bus sequencer, interval timer and
//   shifter update with each request, so the rate is set only by the
//   two-entry output buffer, which absorbs one stalled result.
//   When the receiver stalls, the output register holds its result and the
//   next result lands in the skid register; o_in_stall rises once the skid
//   register is full and falls when it drains.
//   Timing registers are written on the config channel (i_cfg_valid /
//   o_cfg_ready, always ready); the user must do so only while the master is
//   idle, which the block does not enforce. Reset (synchronous, i_rst_n low):
//   sequencer idle, timers at defaults, output buffer empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [7:0]                   i_tx_byte,
    input  logic                         i_line_level,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_pull_low,
    output logic                         o_busy_res,
    output logic                         o_done_res,
    output logic [1:0]                   o_status,
    output logic [7:0]                   o_rx_byte,
    // timing register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [owm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [owm_pkg::TimeW-1:0]    i_cfg_data
);

    // Sequencer phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_R_LOW   = 4'd1;
    localparam logic [3:0] PH_R_SHORT = 4'd2;
    localparam logic [3:0] PH_R_PRES  = 4'd3;
    localparam logic [3:0] PH_R_TAIL  = 4'd4;
    localparam logic [3:0] PH_W_OPEN  = 4'd5;
    localparam logic [3:0] PH_W_DATA  = 4'd6;
    localparam logic [3:0] PH_W_REC   = 4'd7;
    localparam logic [3:0] PH_RD_OPEN = 4'd8;
    localparam logic [3:0] PH_RD_WAIT = 4'd9;
    localparam logic [3:0] PH_RD_TAIL = 4'd10;

    logic [owm_pkg::TimeW-1:0]   r_cfg [owm_pkg::NumCfg];

    logic [3:0]                  r_phase,  n_phase;
    logic [owm_pkg::TimeW-1:0]   r_timer,  n_timer;
    logic [owm_pkg::BitCntW-1:0] r_bit,    n_bit;
    logic [7:0]                  r_shift,  n_shift;

    owm_pkg::t_result            r_out, r_skid, n_res;
    logic                        r_out_valid, r_skid_valid;

    logic                        accept;
    logic                        cur_busy;
    logic                        done;
    logic [1:0]                  status;
    logic [7:0]                  rx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;

    // Timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < owm_pkg::NumCfg; i++) begin
                r_cfg[i] <= owm_pkg::cfg_reset_val(owm_pkg::CfgIdxW'(i));
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Bus sequencer: one request per cycle while the skid register is empty
    assign cur_busy = (r_phase >= PH_R_LOW) && (r_phase <= PH_RD_TAIL);

    always_comb begin
        n_phase = cur_busy ? r_phase : PH_IDLE;
        n_timer = r_timer;
        n_bit   = r_bit;
        n_shift = r_shift;
        done    = 1'b0;
        status  = owm_pkg::ST_OK;
        rx      = 8'd0;

        if (i_op != owm_pkg::OP_TICK) begin
            if (cur_busy) begin
                status = owm_pkg::ST_BUSY;
            end else begin
                n_bit = '0;
                if (i_op == owm_pkg::OP_RESET) begin
                    n_phase = PH_R_LOW;
                    n_timer = r_cfg[owm_pkg::CFG_RESET_LOW];
                end else if (i_op == owm_pkg::OP_WRITE) begin
                    n_shift = i_tx_byte;
                    n_phase = PH_W_OPEN;
                    n_timer = r_cfg[owm_pkg::CFG_SLOT_EDGE];
                end else begin
                    n_shift = 8'd0;
                    n_phase = PH_RD_OPEN;
                    n_timer = r_cfg[owm_pkg::CFG_SLOT_EDGE];
                end
            end
        end else if (cur_busy) begin
            if (r_timer > owm_pkg::TimeW'(1)) begin
                n_timer = r_timer - owm_pkg::TimeW'(1);
            end else begin
                n_timer = '0;
                unique case (r_phase)
                    PH_R_LOW: begin
                        n_phase = PH_R_SHORT;
                        n_timer = r_cfg[owm_pkg::CFG_SHORT_CHK];
                    end
                    PH_R_SHORT: begin
                        if (!i_line_level) begin
                            done   = 1'b1;
                            status = owm_pkg::ST_SHORT;
                        end else begin
                            n_phase = PH_R_PRES;
                            n_timer = r_cfg[owm_pkg::CFG_PRES_WAIT];
                        end
                    end
                    PH_R_PRES: begin
                        if (i_line_level) begin
                            done   = 1'b1;
                            status = owm_pkg::ST_NODEV;
                        end else begin
                            n_phase = PH_R_TAIL;
                            n_timer = r_cfg[owm_pkg::CFG_RESET_TAIL];
                        end
                    end
                    PH_R_TAIL: begin
                        done = 1'b1;
                    end
                    PH_W_OPEN: begin
                        n_phase = PH_W_DATA;
                        n_timer = r_cfg[owm_pkg::CFG_WRITE_SLOT];
                    end
                    PH_W_DATA: begin
                        n_phase = PH_W_REC;
                        n_timer = r_cfg[owm_pkg::CFG_SLOT_EDGE];
                    end
                    PH_W_REC: begin
                        if (r_bit == owm_pkg::LAST_BIT) begin
                            done = 1'b1;
                        end else begin
                            n_bit   = r_bit + owm_pkg::BitCntW'(1);
                            n_shift = {1'b0, r_shift[7:1]};
                            n_phase = PH_W_OPEN;
                            n_timer = r_cfg[owm_pkg::CFG_SLOT_EDGE];
                        end
                    end
                    PH_RD_OPEN: begin
                        n_phase = PH_RD_WAIT;
                        n_timer = r_cfg[owm_pkg::CFG_READ_SAMP];
                    end
                    PH_RD_WAIT: begin
                        // sampled bit enters at the top, LSB ends at bit 0
                        n_shift = {i_line_level, r_shift[7:1]};
                        n_phase = PH_RD_TAIL;
                        n_timer = r_cfg[owm_pkg::CFG_READ_TAIL];
                    end
                    default: begin
                        // read slot tail
                        if (r_bit == owm_pkg::LAST_BIT) begin
                            done = 1'b1;
                            rx   = r_shift;
                        end else begin
                            n_bit   = r_bit + owm_pkg::BitCntW'(1);
                            n_phase = PH_RD_OPEN;
                            n_timer = r_cfg[owm_pkg::CFG_SLOT_EDGE];
                        end
                    end
                endcase
                if (done) begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                end
            end
        end

        // result as seen after this request
        n_res.busy_res = (n_phase >= PH_R_LOW) && (n_phase <= PH_RD_TAIL);
        n_res.pull_low = (n_phase == PH_R_LOW) || (n_phase == PH_W_OPEN) ||
                         (n_phase == PH_RD_OPEN) ||
                         ((n_phase == PH_W_DATA) && !n_shift[0]);
        n_res.done_res = done;
        n_res.status   = status;
        n_res.rx_byte  = rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_bit   <= '0;
            r_shift <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bit   <= n_bit;
            r_shift <= n_shift;
        end
    end

    // Output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pull_low  = r_out.pull_low;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_status    = r_out.status;
    assign o_rx_byte   = r_out.rx_byte;

endmodule
